>>> hw/rtl/round_robin_voice_allocator_top_macros.svh
// Assertion macros shared by the voice allocator checker.
`ifndef ROUND_ROBIN_VOICE_ALLOCATOR_TOP_MACROS_SVH
`define ROUND_ROBIN_VOICE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define RRVA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrva: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define RRVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrva: next-cycle check failed");

`endif

>>> hw/rtl/rrva_pkg.sv
// Shared constants, types and item codes of the round robin voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package rrva_pkg;

  localparam int unsigned VOICES  = 8;
  localparam int unsigned PITCHES = 128;

  localparam int unsigned PITCH_W = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned REQ_W   = 5;

  localparam int unsigned VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned MAP_AW  = $clog2(PITCHES);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef logic [VOICE_W-1:0]      voice_t;
  typedef logic [VOICE_W:0]        vsum_t;
  typedef logic [VOICES-1:0]       vmask_t;
  typedef logic [MAP_AW-1:0]       map_addr_t;
  typedef logic [8:0]              pcmp_t;
  typedef logic signed [REQ_W-1:0] req_t;
  typedef logic [REQ_W-1:0]        ureq_t;

  localparam req_t REQ_NONE = '1;

  // What the back end has to do with an item.
  typedef enum logic [1:0] {
    OP_PASS,
    OP_SEARCH,
    OP_MAP,
    OP_DIRECT
  } op_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    op_t       op;
    logic      note_on;
    logic      map_ok;
    map_addr_t addr;
    voice_t    dvoice;
    req_t      req;
  } qent_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

>>> hw/rtl/round_robin_voice_allocator_top.sv
// Top level of the round robin voice allocator with its configuration register.
//
//   Channel   Direction  Handshake                      Payload
//   input     in         start / busy                   in_pitch, in_velocity, in_voice_request
//   result    out        out_valid (one-cycle strobe)   out_voice, out_stolen
//   config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An item is taken at an edge where start is high and busy is low. The front end
// classifies it and stores it in a two-entry queue; busy is high only while that
// queue is full. The back end pops an item and reads the pitch map memory in its
// idle state, then searches the voices, updates state and loads the result register
// in its exec state; it pops no new item before it has finished the last one. The
// queue slot, the payload registers and the result register lie between an item
// being taken and its result. The receiver cannot stall, so results never wait.
// Reset is synchronous and immediate: the pitch map's entries carry valid bits in
// flip-flops, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_voice_allocator_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input items.
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [rrva_pkg::PITCH_W-1:0]         in_pitch,
  input  wire logic [rrva_pkg::VEL_W-1:0]           in_velocity,
  input  wire logic signed [rrva_pkg::REQ_W-1:0]    in_voice_request,
  // Result items.
  output logic                                      out_valid,
  output logic signed [rrva_pkg::REQ_W-1:0]         out_voice,
  output logic                                      out_stolen,
  // Configuration port.
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  logic             enabled_r;
  logic             cfg_wr;
  logic             busy_clr;
  logic             push;
  logic             pop;
  rrva_pkg::qent_t  ent;
  rrva_pkg::qent_t  qdata;
  rrva_pkg::qstat_t qstat;

  // The only register, enabled, sits at byte address 0; paddr[2] picks the
  // register and anything above it is ignored on write and reads as zero.
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && !paddr[2];
  // Turning allocation off drops every busy mark; pointer and map stay as they are.
  assign busy_clr = cfg_wr && !pwdata[0];
  assign prdata   = paddr[2] ? '0 : {31'b0, enabled_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
    end else if (cfg_wr) begin
      enabled_r <= pwdata[0];
    end
  end

  rrva_front u_front (
    .start            (start),
    .enabled          (enabled_r),
    .qstat            (qstat),
    .in_pitch         (in_pitch),
    .in_velocity      (in_velocity),
    .in_voice_request (in_voice_request),
    .busy             (busy),
    .push             (push),
    .ent              (ent)
  );

  rrva_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (ent),
    .pop   (pop),
    .rdata (qdata),
    .qstat (qstat)
  );

  rrva_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .qdata      (qdata),
    .busy_clr   (busy_clr),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_voice  (out_voice),
    .out_stolen (out_stolen)
  );

endmodule

`default_nettype wire

>>> hw/rtl/rrva_front.sv
// Front end: takes items from the command port and classifies them.
`timescale 1ns / 1ps
`default_nettype none

module rrva_front (
  input  wire logic                           start,
  input  wire logic                           enabled,
  input  wire rrva_pkg::qstat_t               qstat,
  input  wire logic [rrva_pkg::PITCH_W-1:0]   in_pitch,
  input  wire logic [rrva_pkg::VEL_W-1:0]     in_velocity,
  input  wire logic signed [rrva_pkg::REQ_W-1:0] in_voice_request,
  output logic                                busy,
  output logic                                push,
  output rrva_pkg::qent_t                     ent
);

  logic req_in_range;

  assign busy = qstat.full;
  assign push = start && !qstat.full;

  // A request names a voice directly only when it is non-negative and below VOICES.
  assign req_in_range = !in_voice_request[rrva_pkg::REQ_W-1] &&
                        (rrva_pkg::ureq_t'($unsigned(in_voice_request)) <
                         rrva_pkg::ureq_t'(rrva_pkg::VOICES));

  always_comb begin
    ent.note_on = (in_velocity != '0);
    ent.map_ok  = rrva_pkg::pcmp_t'(in_pitch) < rrva_pkg::pcmp_t'(rrva_pkg::PITCHES);
    ent.addr    = rrva_pkg::map_addr_t'(in_pitch);
    ent.req     = in_voice_request;
    ent.dvoice  = req_in_range ? rrva_pkg::voice_t'($unsigned(in_voice_request)) : '0;
    if (!enabled) begin
      ent.op = rrva_pkg::OP_PASS;
    end else if (in_voice_request == rrva_pkg::REQ_NONE) begin
      ent.op = ent.note_on ? rrva_pkg::OP_SEARCH : rrva_pkg::OP_MAP;
    end else begin
      ent.op = rrva_pkg::OP_DIRECT;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rrva_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module rrva_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rrva_pkg::qent_t wdata,
  input  wire logic            pop,
  output rrva_pkg::qent_t      rdata,
  output rrva_pkg::qstat_t     qstat
);

  rrva_pkg::qent_t              slot_r [rrva_pkg::QDEPTH];
  logic [rrva_pkg::QAW-1:0]     wp_r, wp_nxt;
  logic [rrva_pkg::QAW-1:0]     rp_r, rp_nxt;
  logic [rrva_pkg::QAW:0]       cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  assign rdata       = slot_r[rp_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == (rrva_pkg::QAW + 1)'(rrva_pkg::QDEPTH));

endmodule

`default_nettype wire

>>> hw/rtl/rrva_back.sv
// Back end: voice search, pitch map, busy marks and result register.
`timescale 1ns / 1ps
`default_nettype none

module rrva_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rrva_pkg::qstat_t      qstat,
  input  wire rrva_pkg::qent_t       qdata,
  input  wire logic                  busy_clr,
  output logic                       pop,
  output logic                       out_valid,
  output logic signed [rrva_pkg::REQ_W-1:0] out_voice,
  output logic                       out_stolen
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  bstate_t st_r, st_nxt;

  rrva_pkg::qent_t   cur_r;
  rrva_pkg::voice_t  ptr_r, ptr_nxt;
  rrva_pkg::vmask_t  busy_r;
  logic [rrva_pkg::PITCHES-1:0] map_vld_r;
  rrva_pkg::voice_t  map_mem [rrva_pkg::PITCHES];
  rrva_pkg::voice_t  rd_r;
  logic              rd_vld_r;

  logic              out_valid_r;
  rrva_pkg::req_t    out_voice_r;
  logic              out_stolen_r;

  logic [2*rrva_pkg::VOICES-1:0] free2;
  rrva_pkg::vmask_t  rot;
  rrva_pkg::voice_t  off;
  logic              found;
  rrva_pkg::vsum_t   sum;
  rrva_pkg::voice_t  cand;
  rrva_pkg::voice_t  v;
  logic              stolen;
  logic              exec;
  logic              upd;

  assign pop  = (st_r == B_IDLE) && !qstat.empty;
  assign exec = (st_r == B_EXEC);
  assign upd  = exec && (cur_r.op != rrva_pkg::OP_PASS);

  always_comb begin
    unique case (st_r)
      B_IDLE:  st_nxt = pop ? B_EXEC : B_IDLE;
      B_EXEC:  st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // Rotating search: free marks rotated so the pointer voice sits at bit 0,
  // then the lowest set bit is the distance to the first free voice.
  always_comb begin
    free2 = {~busy_r, ~busy_r};
    rot   = rrva_pkg::vmask_t'(free2 >> ptr_r);
    found = 1'b0;
    off   = '0;
    for (int i = rrva_pkg::VOICES - 1; i >= 0; i--) begin
      if (rot[i]) begin
        found = 1'b1;
        off   = rrva_pkg::voice_t'(i);
      end
    end
    sum  = {1'b0, ptr_r} + {1'b0, off};
    cand = (sum >= rrva_pkg::vsum_t'(rrva_pkg::VOICES)) ?
           rrva_pkg::voice_t'(sum - rrva_pkg::vsum_t'(rrva_pkg::VOICES)) :
           rrva_pkg::voice_t'(sum);
    ptr_nxt = (ptr_r == rrva_pkg::voice_t'(rrva_pkg::VOICES - 1)) ? '0 : ptr_r + 1'b1;
  end

  always_comb begin
    v      = '0;
    stolen = 1'b0;
    unique case (cur_r.op)
      rrva_pkg::OP_PASS:   v = '0;
      rrva_pkg::OP_SEARCH: begin
        v      = found ? cand : ptr_r;
        stolen = !found;
      end
      rrva_pkg::OP_MAP:    v = rd_vld_r ? rd_r : '0;
      rrva_pkg::OP_DIRECT: v = cur_r.dvoice;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_IDLE;
      ptr_r        <= '0;
      busy_r       <= '0;
      map_vld_r    <= '0;
      out_valid_r  <= 1'b0;
      out_stolen_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_valid_r  <= exec;
      out_stolen_r <= exec && stolen;
      if (exec && (cur_r.op == rrva_pkg::OP_SEARCH)) begin
        ptr_r <= ptr_nxt;
      end
      if (busy_clr) begin
        busy_r <= '0;
      end else if (upd) begin
        busy_r[v] <= cur_r.note_on;
      end
      if (upd && cur_r.map_ok) begin
        map_vld_r[cur_r.addr] <= cur_r.note_on;
      end
    end
  end

  // Payload registers, the pitch map storage and the result voice register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r    <= qdata;
      rd_r     <= map_mem[qdata.addr];
      rd_vld_r <= qdata.map_ok && map_vld_r[qdata.addr];
    end
    if (upd && cur_r.map_ok && cur_r.note_on) begin
      map_mem[cur_r.addr] <= v;
    end
    if (exec) begin
      out_voice_r <= (cur_r.op == rrva_pkg::OP_PASS) ? cur_r.req :
                     rrva_pkg::req_t'({{(rrva_pkg::REQ_W - rrva_pkg::VOICE_W){1'b0}}, v});
    end
  end

  assign out_valid  = out_valid_r;
  assign out_voice  = out_voice_r;
  assign out_stolen = out_stolen_r;

endmodule

`default_nettype wire

>>> hw/rtl/rrva_checker.sv
// Port-level checks of the voice allocator and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_voice_allocator_top_macros.svh"

module rrva_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              out_valid,
  input wire logic signed [rrva_pkg::REQ_W-1:0] out_voice,
  input wire logic                              out_stolen
);

  // The back end returns to idle between items, so strobes never come back to back.
  `RRVA_ASSERT_NEXT(a_strobe_spacing, out_valid, !out_valid)

  // A steal mark only travels with a result.
  `RRVA_ASSERT_IMPL(a_stolen_with_valid, out_stolen, out_valid)

  // A stolen voice is a real voice, never the pass-through of a negative request.
  `RRVA_ASSERT_IMPL(a_stolen_voice, out_stolen, !out_voice[rrva_pkg::REQ_W-1])

  // The queue only fills through taken items, so busy rises right after one.
  `RRVA_ASSERT_IMPL(a_busy_cause, busy, $past(start && !busy) || $past(busy))

endmodule

bind round_robin_voice_allocator_top rrva_checker u_rrva_checker (.*);

`default_nettype wire

>>> tb/round_robin_voice_allocator_top_tb.sv
// Self-checking testbench for the round robin voice allocator top level.
`timescale 1ns / 1ps

module round_robin_voice_allocator_top_tb;
  import rrva_pkg::*;

  // Register map: the enable bit sits at byte address 0. Address 4 decodes
  // to no register, so a write there must leave everything untouched.
  localparam logic [2:0] ENABLED_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR   = 3'd4;

  localparam int              NV        = VOICES;
  localparam int              NO_VOICE  = -1;
  localparam logic [VEL_W-1:0] VEL_OFF  = '0;
  localparam int              GAP_MAX   = 15;
  // Extra idle time at the end of a drain, as a margin.
  localparam int              SETTLE_CYCLES = 8;
  localparam int              DRAIN_LIMIT   = 2000;
  localparam int              PHASES        = 8;
  localparam int              PHASE_ITEMS   = 200;

  // One allocation as it should appear on the result ports.
  typedef struct packed {
    req_t voice;
    logic stolen;
  } alloc_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [PITCH_W-1:0]          in_pitch = '0;
  logic [VEL_W-1:0]            in_velocity = '0;
  logic signed [REQ_W-1:0]     in_voice_request = '0;
  logic                        out_valid;
  logic signed [REQ_W-1:0]     out_voice;
  logic                        out_stolen;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [2:0]                  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  round_robin_voice_allocator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pitch         (in_pitch),
    .in_velocity      (in_velocity),
    .in_voice_request (in_voice_request),
    .out_valid        (out_valid),
    .out_voice        (out_voice),
    .out_stolen       (out_stolen),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Our own copy of the allocator state. It is advanced once per accepted
  // item and once per register write, in the same order the block sees them.
  logic   alloc_enabled = 1'b1;
  vmask_t busy_voices = '0;
  voice_t rr_ptr = '0;
  int     pitch_voice[PITCHES];

  // Allocations predicted for accepted items whose results have not come yet.
  alloc_t pending_allocs[$];
  // Pitches currently sounding, so that random note-offs mostly hit real notes.
  int     held_pitches[$];

  int unsigned fail_count = 0;
  // When set, the sender never idles between items.
  bit          steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out which voice an item gets and update the allocator state.
  function automatic alloc_t allocate_voice(input logic [PITCH_W-1:0] p,
                                            input logic [VEL_W-1:0] vel,
                                            input req_t req);
    alloc_t res;
    int     v;
    int     cand;
    logic   note_on;
    logic   found;
    res.voice  = req;
    res.stolen = 1'b0;
    if (!alloc_enabled) begin
      // Disabled: the request passes straight through and nothing changes.
      return res;
    end
    note_on = (vel != VEL_OFF);
    v = req;
    if (req == REQ_NONE) begin
      if (note_on) begin
        // Search upward from the pointer for a free voice; steal the
        // pointer voice if all are busy. The pointer moves by one either way.
        found = 1'b0;
        for (int i = 0; i < NV; i++) begin
          cand = (int'(rr_ptr) + i) % NV;
          if (!found && !busy_voices[cand]) begin
            v = cand;
            found = 1'b1;
          end
        end
        if (!found) begin
          v = int'(rr_ptr);
          res.stolen = 1'b1;
        end
        rr_ptr = voice_t'((int'(rr_ptr) + 1) % NV);
      end else begin
        v = pitch_voice[p];
      end
    end
    // A missing mapping or any voice outside the pool falls back to voice 0.
    if (v < 0 || v >= NV) v = 0;
    busy_voices[v] = note_on;
    pitch_voice[p] = note_on ? v : NO_VOICE;
    res.voice = req_t'(v);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Offer one item, after a random gap unless steady is set, and hold it until busy lets it in.
  task automatic send_note(input logic [PITCH_W-1:0] p, input logic [VEL_W-1:0] vel,
                           input req_t req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_pitch         <= p;
    in_velocity      <= vel;
    in_voice_request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_allocs.push_back(allocate_voice(p, vel, req));
  endtask

  // Stop offering items and wait until every predicted result has arrived.
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending_allocs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_allocs.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_allocs.size());
      pending_allocs.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register over the APB port, then read the enable bit back.
  // Only called while the block is idle.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ENABLED_ADDR) begin
      alloc_enabled = data[0];
      // Every write of zero drops all busy marks; pointer and map stay.
      if (!data[0]) busy_voices = '0;
    end
    @(posedge clk);
    psel    <= 1'b1;
    paddr   <= ENABLED_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== alloc_enabled) begin
      report_mismatch("enabled read back", int'(prdata[0]), int'(alloc_enabled));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Compare each result strobe with the oldest prediction.
  always @(posedge clk) begin
    alloc_t want;
    if (rst_n && out_valid) begin
      if (pending_allocs.size() == 0) begin
        report_mismatch("result with no item pending", int'(out_voice), 0);
      end else begin
        want = pending_allocs.pop_front();
        if (out_voice !== want.voice) begin
          report_mismatch("voice", int'(out_voice), int'(want.voice));
        end
        if (out_stolen !== want.stolen) begin
          report_mismatch("stolen", int'(out_stolen), int'(want.stolen));
        end
      end
    end
  end

  // Field extremes, both request kinds, out-of-range requests, map hits and
  // misses, and a full pool that forces steals.
  task automatic test_directed();
    send_note(7'd0, 7'd127, REQ_NONE);
    send_note(7'd127, 7'd1, REQ_NONE);
    // Requests outside the pool, positive and negative, end up on voice 0; NV - 1 is in range.
    send_note(7'd5, 7'd64, req_t'(15));
    send_note(7'd6, 7'd64, req_t'(NV - 1));
    send_note(7'd7, 7'd64, req_t'(-16));
    send_note(7'd8, 7'd64, req_t'(-2));
    // Note-offs through the pitch map, including a pitch with no mapping, and one direct note-off.
    send_note(7'd0, VEL_OFF, REQ_NONE);
    send_note(7'd127, VEL_OFF, REQ_NONE);
    send_note(7'd64, VEL_OFF, REQ_NONE);
    send_note(7'd9, VEL_OFF, req_t'(3));
    // Back to back note-ons until every voice is taken and steals begin.
    steady = 1'b1;
    for (int i = 0; i < NV + 2; i++) begin
      send_note(7'(20 + i), 7'(100 + i), REQ_NONE);
    end
    steady = 1'b0;
    send_note(7'd20, VEL_OFF, REQ_NONE);
    send_note(7'd21, VEL_OFF, req_t'(-16));
    drain();
  endtask

  // Disabled pass-through, the busy clear on disable, and a write to an
  // address with no register behind it.
  task automatic test_disable();
    cfg_write(ENABLED_ADDR, 32'h0000_0000);
    send_note(7'd30, 7'd50, REQ_NONE);
    send_note(7'd31, VEL_OFF, REQ_NONE);
    send_note(7'd32, 7'd127, req_t'(-16));
    send_note(7'd33, 7'd1, req_t'(15));
    drain();
    cfg_write(SPARE_ADDR, 32'h0000_0001);
    send_note(7'd34, 7'd10, REQ_NONE);
    drain();
    cfg_write(ENABLED_ADDR, 32'hFFFF_FFFF);
    // Busy marks were cleared, so the search finds a free voice at the pointer.
    send_note(7'd35, 7'd10, REQ_NONE);
    send_note(7'd35, VEL_OFF, REQ_NONE);
    drain();
  endtask

  // Mostly note-on / note-off pairs through the allocator, with direct
  // requests and raw noise mixed in.
  task automatic random_note();
    int                 kind;
    int                 idx;
    logic [PITCH_W-1:0] p;
    logic [VEL_W-1:0]   vel;
    req_t               req;
    kind = $urandom_range(0, 99);
    if (kind < 30 && held_pitches.size() > 0) begin
      idx = $urandom_range(0, held_pitches.size() - 1);
      p   = PITCH_W'(held_pitches[idx]);
      held_pitches.delete(idx);
      vel = VEL_OFF;
      req = REQ_NONE;
    end else if (kind < 80) begin
      p   = PITCH_W'($urandom());
      vel = VEL_W'($urandom_range(1, 127));
      req = REQ_NONE;
      held_pitches.push_back(int'(p));
      if (held_pitches.size() > 4 * NV) void'(held_pitches.pop_front());
    end else if (kind < 90) begin
      p   = PITCH_W'($urandom());
      vel = $urandom_range(0, 1) ? VEL_OFF : VEL_W'($urandom());
      req = req_t'($urandom_range(0, NV - 1));
    end else begin
      p   = PITCH_W'($urandom());
      vel = VEL_W'($urandom());
      req = req_t'($urandom());
    end
    send_note(p, vel, req);
  endtask

  task automatic test_random();
    logic [31:0] cfg_val;
    for (int ph = 0; ph < PHASES; ph++) begin
      // Upper bits are junk; only bit 0 matters. Two phases run disabled.
      cfg_val    = $urandom();
      cfg_val[0] = (ph != 3 && ph != 6);
      cfg_write(ENABLED_ADDR, cfg_val);
      steady = (ph == 2 || ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_note();
      end
      steady = 1'b0;
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < PITCHES; i++) pitch_voice[i] = NO_VOICE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_disable();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rrva_pkg.sv
hw/rtl/rrva_front.sv
hw/rtl/rrva_queue.sv
hw/rtl/rrva_back.sv
hw/rtl/round_robin_voice_allocator_top.sv
hw/rtl/rrva_checker.sv
tb/round_robin_voice_allocator_top_tb.sv
